FILE: sv/udr_pkg.sv
// ----------------------------------------------------------------------------
// udr_pkg
// Shared types and constants of the diagnostic responder: service and
// response codes, state encodings, queue entry and configuration record.
// ----------------------------------------------------------------------------
`default_nettype none

package udr_pkg;

    // service identifiers and fixed response bytes
    localparam logic [7:0] SID_SESSION     = 8'h10;
    localparam logic [7:0] SID_ECU_RESET   = 8'h11;
    localparam logic [7:0] SID_READ_ID     = 8'h22;
    localparam logic [7:0] SID_SEC_ACCESS  = 8'h27;
    localparam logic [7:0] SID_DOWNLOAD    = 8'h34;
    localparam logic [7:0] SID_TESTER      = 8'h3E;
    localparam logic [7:0] SID_NEGATIVE    = 8'h7F;
    localparam logic [7:0] SID_READ_ID_POS = 8'h62;
    localparam logic [7:0] POS_OFFSET      = 8'h40;

    // negative response codes
    localparam logic [7:0] NRC_GENERAL      = 8'h10;
    localparam logic [7:0] NRC_NOT_SUPP     = 8'h11;
    localparam logic [7:0] NRC_SUB_NOT_SUPP = 8'h12;
    localparam logic [7:0] NRC_SEQUENCE     = 8'h24;
    localparam logic [7:0] NRC_OUT_OF_RANGE = 8'h31;
    localparam logic [7:0] NRC_INVALID_KEY  = 8'h35;
    localparam logic [7:0] NRC_EXCEEDED     = 8'h36;
    localparam logic [7:0] NRC_DELAY        = 8'h37;
    localparam logic [7:0] NRC_WRONG_SESS   = 8'h7E;

    // sub-functions
    localparam logic [7:0] SUB_DEFAULT_SESS = 8'h01;
    localparam logic [7:0] SUB_PROG_SESS    = 8'h02;
    localparam logic [7:0] SUB_EXT_SESS     = 8'h03;
    localparam logic [7:0] SUB_HARD_RESET   = 8'h01;
    localparam logic [7:0] SUB_SHUTDOWN     = 8'h04;
    localparam logic [7:0] SUB_SEED         = 8'h01;
    localparam logic [7:0] SUB_KEY          = 8'h02;
    localparam logic [7:0] SUB_DOWNLOAD     = 8'h00;
    localparam logic [7:0] SUB_TESTER       = 8'h01;

    // data identifiers
    localparam logic [15:0] DID_BOOT    = 16'hF180;
    localparam logic [15:0] DID_APPL    = 16'hF181;
    localparam logic [15:0] DID_SESSION = 16'hF186;

    localparam logic [1:0] MODE_BOOT = 2'd0;
    localparam logic [1:0] MODE_APPL = 2'd1;

    // configuration register map
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_APPL  = 3'd4;

    localparam logic [31:0] RST_SEED  = 32'hAABBCCDD;
    localparam logic [31:0] RST_KEY   = 32'hABBCCDDE;
    localparam logic [1:0]  RST_LIMIT = 2'd3;
    localparam logic [31:0] RST_BOOT  = 32'h424C5632;
    localparam logic [31:0] RST_APPL  = 32'h41503232;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        SESS_DEFAULT = 2'd1,
        SESS_PROG    = 2'd2,
        SESS_EXT     = 2'd3
    } t_session;

    typedef enum logic [2:0] {
        SEC_LOCKED    = 3'd0,
        SEC_SEQ_ERROR = 3'd1,
        SEC_DENIED    = 3'd2,
        SEC_EXCEEDED  = 3'd3,
        SEC_DELAY     = 3'd4,
        SEC_SEED_REQ  = 3'd5,
        SEC_UNLOCKED  = 3'd6
    } t_sec;

    typedef enum logic [1:0] {
        REQ_NONE       = 2'd0,
        REQ_RESET_APPL = 2'd1,
        REQ_REPROG     = 2'd2,
        REQ_SHUTDOWN   = 2'd3
    } t_ecu_req;

    typedef enum logic [2:0] {
        OP_SESSION,
        OP_RESET,
        OP_READ_ID,
        OP_SEC,
        OP_DOWNLOAD,
        OP_TESTER,
        OP_UNKNOWN
    } t_op;

    typedef enum logic [1:0] {
        IDC_BOOT,
        IDC_APPL,
        IDC_SESSION,
        IDC_OTHER
    } t_idcls;

    typedef struct packed {
        t_op         op;
        t_idcls      idc;
        logic [7:0]  sid;
        logic [7:0]  sub;
        logic [7:0]  low;
        logic [31:0] key;
        logic [1:0]  mode;
    } t_cmd;

    typedef struct packed {
        logic [31:0] seed;
        logic [31:0] key;
        logic [1:0]  limit;
        logic [31:0] boot;
        logic [31:0] appl;
    } t_cfg;

endpackage

`default_nettype wire

FILE: sv/udr_req_if.sv
// ----------------------------------------------------------------------------
// udr_req_if
// Request channel: decoded diagnostic request with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface udr_req_if;
    logic        valid;
    logic        ready;
    logic [7:0]  service_id;
    logic [7:0]  request_sub;
    logic [7:0]  request_low;
    logic [31:0] key_word;
    logic [1:0]  ecu_mode;

    modport source (
        output valid, service_id, request_sub, request_low, key_word, ecu_mode,
        input  ready
    );
    modport sink (
        input  valid, service_id, request_sub, request_low, key_word, ecu_mode,
        output ready
    );
endinterface

`default_nettype wire

FILE: sv/udr_rsp_if.sv
// ----------------------------------------------------------------------------
// udr_rsp_if
// Response channel: packed response bytes and ECU manager request.
// ----------------------------------------------------------------------------
`default_nettype none

interface udr_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  response_length;
    logic [55:0] response_data;
    logic [1:0]  ecu_request;

    modport source (
        output valid, response_length, response_data, ecu_request,
        input  ready
    );
    modport sink (
        input  valid, response_length, response_data, ecu_request,
        output ready
    );
endinterface

`default_nettype wire

FILE: sv/udr_front.sv
// ----------------------------------------------------------------------------
// udr_front
// Accepts requests and classifies them by service and identifier before
// they enter the command queue.
// ----------------------------------------------------------------------------
`default_nettype none

module udr_front
    import udr_pkg::*;
(
    udr_req_if.sink i_req,
    input  logic    i_q_ready,
    output logic    o_push,
    output t_cmd    o_cmd
);

    logic [15:0] ident;

    always_comb begin
        ident       = {i_req.request_sub, i_req.request_low};
        i_req.ready = i_q_ready;
        o_push      = i_req.valid && i_q_ready;

        o_cmd.sid  = i_req.service_id;
        o_cmd.sub  = i_req.request_sub;
        o_cmd.low  = i_req.request_low;
        o_cmd.key  = i_req.key_word;
        o_cmd.mode = i_req.ecu_mode;

        case (i_req.service_id)
            SID_SESSION:    o_cmd.op = OP_SESSION;
            SID_ECU_RESET:  o_cmd.op = OP_RESET;
            SID_READ_ID:    o_cmd.op = OP_READ_ID;
            SID_SEC_ACCESS: o_cmd.op = OP_SEC;
            SID_DOWNLOAD:   o_cmd.op = OP_DOWNLOAD;
            SID_TESTER:     o_cmd.op = OP_TESTER;
            default:        o_cmd.op = OP_UNKNOWN;
        endcase

        case (ident)
            DID_BOOT:    o_cmd.idc = IDC_BOOT;
            DID_APPL:    o_cmd.idc = IDC_APPL;
            DID_SESSION: o_cmd.idc = IDC_SESSION;
            default:     o_cmd.idc = IDC_OTHER;
        endcase
    end

endmodule

`default_nettype wire

FILE: sv/udr_queue.sv
// ----------------------------------------------------------------------------
// udr_queue
// Two-entry command queue between the classifier and the executing stage.
// Push and pop may fall in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module udr_queue
    import udr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_ready,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    always_comb begin
        o_ready  = (r_count != FULL);
        o_valid  = (r_count != '0);
        o_cmd    = r_mem[r_rd_ptr];
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL)
        else $error("queue count beyond depth");

    a_no_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("pop from empty queue");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not follow a lone push");

endmodule

`default_nettype wire

FILE: sv/udr_back.sv
// ----------------------------------------------------------------------------
// udr_back
// Executes queued requests against session and security-access state and
// holds the finished response in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module udr_back
    import udr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_valid,
    input  t_cmd      i_cmd,
    output logic      o_pop,
    udr_rsp_if.source o_rsp
);

    typedef struct packed {
        logic [2:0]  len;
        logic [55:0] data;
        t_ecu_req    req;
    } t_resp;

    function automatic t_resp f_pos2(input logic [7:0] sid, input logic [7:0] sub);
        t_resp r;
        r.len  = 3'd2;
        r.data = {40'd0, sid + POS_OFFSET, sub};
        r.req  = REQ_NONE;
        return r;
    endfunction

    function automatic t_resp f_neg(input logic [7:0] sid, input logic [7:0] code);
        t_resp r;
        r.len  = 3'd3;
        r.data = {32'd0, SID_NEGATIVE, sid, code};
        r.req  = REQ_NONE;
        return r;
    endfunction

    t_session    r_session, n_session;
    t_sec        r_sec, n_sec;
    logic [1:0]  r_failed, n_failed;
    logic        r_out_valid;
    t_resp       r_out;
    t_resp       rsp;
    logic [1:0]  fa_inc;
    logic        seed_ev, key_ev;
    logic [31:0] ident_word;

    always_comb begin
        n_session  = r_session;
        n_sec      = r_sec;
        n_failed   = r_failed;
        seed_ev    = (i_cmd.sub == SUB_SEED);
        key_ev     = (i_cmd.sub == SUB_KEY);
        fa_inc     = (r_failed == 2'd3) ? 2'd3 : r_failed + 2'd1;
        ident_word = (i_cmd.idc == IDC_BOOT) ? i_cfg.boot : i_cfg.appl;
        rsp        = f_neg(i_cmd.sid, NRC_SUB_NOT_SUPP);

        case (i_cmd.op)
            OP_SESSION: begin
                if (i_cmd.sub == SUB_DEFAULT_SESS) begin
                    rsp = f_pos2(i_cmd.sid, i_cmd.sub);
                    // returning to default from programming restarts the application
                    if (r_session == SESS_PROG) begin
                        rsp.req = REQ_RESET_APPL;
                    end
                    n_session = SESS_DEFAULT;
                end else if (i_cmd.sub == SUB_PROG_SESS) begin
                    if (r_session == SESS_EXT) begin
                        rsp       = f_pos2(i_cmd.sid, i_cmd.sub);
                        rsp.req   = REQ_REPROG;
                        n_session = SESS_PROG;
                    end else begin
                        rsp = f_neg(i_cmd.sid, NRC_WRONG_SESS);
                    end
                end else if (i_cmd.sub == SUB_EXT_SESS) begin
                    rsp       = f_pos2(i_cmd.sid, i_cmd.sub);
                    n_session = SESS_EXT;
                end
            end
            OP_RESET: begin
                if (i_cmd.sub == SUB_HARD_RESET) begin
                    rsp     = f_pos2(i_cmd.sid, i_cmd.sub);
                    rsp.req = REQ_RESET_APPL;
                end else if (i_cmd.sub == SUB_SHUTDOWN) begin
                    rsp     = f_pos2(i_cmd.sid, i_cmd.sub);
                    rsp.req = REQ_SHUTDOWN;
                end
            end
            OP_READ_ID: begin
                case (i_cmd.idc)
                    IDC_BOOT, IDC_APPL: begin
                        if ((i_cmd.idc == IDC_BOOT && i_cmd.mode == MODE_BOOT) ||
                            (i_cmd.idc == IDC_APPL && i_cmd.mode == MODE_APPL)) begin
                            rsp.len  = 3'd7;
                            rsp.data = {SID_READ_ID_POS, i_cmd.sub, i_cmd.low, ident_word};
                            rsp.req  = REQ_NONE;
                        end else begin
                            rsp = f_neg(i_cmd.sid, NRC_OUT_OF_RANGE);
                        end
                    end
                    IDC_SESSION: begin
                        rsp.len  = 3'd4;
                        rsp.data = {24'd0, SID_READ_ID_POS, i_cmd.sub, i_cmd.low,
                                    6'd0, r_session};
                        rsp.req  = REQ_NONE;
                    end
                    default: rsp = f_neg(i_cmd.sid, NRC_SUB_NOT_SUPP);
                endcase
            end
            OP_SEC: begin
                case (r_sec)
                    SEC_LOCKED, SEC_SEQ_ERROR, SEC_DENIED, SEC_EXCEEDED, SEC_DELAY: begin
                        if (seed_ev) begin
                            if (r_failed < i_cfg.limit) begin
                                rsp.len  = 3'd6;
                                rsp.data = {8'd0, SID_SEC_ACCESS + POS_OFFSET, SUB_SEED,
                                            i_cfg.seed};
                                rsp.req  = REQ_NONE;
                                n_sec    = SEC_SEED_REQ;
                            end else begin
                                rsp   = f_neg(SID_SEC_ACCESS, NRC_DELAY);
                                n_sec = SEC_DELAY;
                            end
                        end else if (key_ev) begin
                            rsp   = f_neg(SID_SEC_ACCESS, NRC_SEQUENCE);
                            n_sec = SEC_SEQ_ERROR;
                        end else begin
                            rsp = f_neg(SID_SEC_ACCESS, NRC_SUB_NOT_SUPP);
                        end
                    end
                    SEC_SEED_REQ: begin
                        if (key_ev) begin
                            if (i_cmd.key == i_cfg.key) begin
                                n_failed = 2'd0;
                                rsp      = f_pos2(SID_SEC_ACCESS, SUB_KEY);
                                n_sec    = SEC_UNLOCKED;
                            end else begin
                                n_failed = fa_inc;
                                if (fa_inc < i_cfg.limit) begin
                                    rsp   = f_neg(SID_SEC_ACCESS, NRC_INVALID_KEY);
                                    n_sec = SEC_DENIED;
                                end else begin
                                    rsp   = f_neg(SID_SEC_ACCESS, NRC_EXCEEDED);
                                    n_sec = SEC_EXCEEDED;
                                end
                            end
                        end else if (seed_ev) begin
                            rsp   = f_neg(SID_SEC_ACCESS, NRC_SEQUENCE);
                            n_sec = SEC_SEQ_ERROR;
                        end else begin
                            rsp = f_neg(SID_SEC_ACCESS, NRC_SUB_NOT_SUPP);
                        end
                    end
                    SEC_UNLOCKED: begin
                        if (seed_ev || key_ev) begin
                            rsp   = f_neg(SID_SEC_ACCESS, NRC_SEQUENCE);
                            n_sec = SEC_SEQ_ERROR;
                        end else begin
                            rsp = f_neg(SID_SEC_ACCESS, NRC_SUB_NOT_SUPP);
                        end
                    end
                    default: begin
                        rsp   = f_neg(SID_SEC_ACCESS, NRC_GENERAL);
                        n_sec = SEC_SEQ_ERROR;
                    end
                endcase
            end
            OP_DOWNLOAD: begin
                if (i_cmd.sub == SUB_DOWNLOAD) begin
                    rsp = f_pos2(i_cmd.sid, i_cmd.sub);
                end
            end
            OP_TESTER: begin
                if (i_cmd.sub == SUB_TESTER) begin
                    rsp = f_pos2(i_cmd.sid, i_cmd.sub);
                end
            end
            default: rsp = f_neg(i_cmd.sid, NRC_NOT_SUPP);
        endcase

        // take the next request when the output slot is free or draining
        o_pop = i_valid && (!r_out_valid || o_rsp.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_session   <= SESS_DEFAULT;
            r_sec       <= SEC_LOCKED;
            r_failed    <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_session   <= n_session;
                r_sec       <= n_sec;
                r_failed    <= n_failed;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= rsp;
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.response_length = r_out.len;
    assign o_rsp.response_data   = r_out.data;
    assign o_rsp.ecu_request     = r_out.req;

    a_len_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.len >= 3'd2))
        else $error("response shorter than two bytes");

    a_unlock_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sec == SEC_UNLOCKED) |-> (r_failed == 2'd0))
        else $error("unlocked with failed attempts pending");

    a_reprog_session: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && rsp.req == REQ_REPROG) |=> (r_session == SESS_PROG))
        else $error("reprogramming requested outside programming session");

endmodule

`default_nettype wire

FILE: sv/uds_diagnostic_responder.sv
// ----------------------------------------------------------------------------
// uds_diagnostic_responder
// Diagnostic request server: session control, ECU reset, identifier read,
// seed/key security access, download and tester present.
// ----------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  i_req     in   valid/ready   service_id, request_sub, request_low,
//                               key_word, ecu_mode
//  o_rsp     out  valid/ready   response_length, response_data, ecu_request
//  i_cfg_*   in   write enable  i_cfg_index, i_cfg_data
//
//  One request per cycle sustained while responses are taken; a response
//  passes through the queue, written when its request is taken, and then
//  the execute/output register before it is offered.
//  The two-entry queue lets requests flow in while a response is stalled.
//  Synchronous active-low reset: default session, locked, no failed
//  attempts, configuration back to its defaults, queue and output empty.
// ----------------------------------------------------------------------------
`default_nettype none

module uds_diagnostic_responder
    import udr_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    udr_req_if.sink                    i_req,
    udr_rsp_if.source                  o_rsp,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg r_cfg;
    logic q_ready;
    logic push;
    t_cmd push_cmd;
    logic q_valid;
    t_cmd q_cmd;
    logic pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.seed  <= RST_SEED;
            r_cfg.key   <= RST_KEY;
            r_cfg.limit <= RST_LIMIT;
            r_cfg.boot  <= RST_BOOT;
            r_cfg.appl  <= RST_APPL;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SEED:  r_cfg.seed  <= i_cfg_data;
                CFG_KEY:   r_cfg.key   <= i_cfg_data;
                CFG_LIMIT: r_cfg.limit <= i_cfg_data[1:0];
                CFG_BOOT:  r_cfg.boot  <= i_cfg_data;
                CFG_APPL:  r_cfg.appl  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    udr_front u_front (
        .i_req     (i_req),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_cmd     (push_cmd)
    );

    udr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    udr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (q_valid),
        .i_cmd   (q_cmd),
        .o_pop   (pop),
        .o_rsp   (o_rsp)
    );

endmodule

`default_nettype wire
